[rtl/core/bce_pkg.sv]
package bce_pkg;

  localparam logic [7:0] PREFIX_MAX = 8'd83;
  localparam logic [7:0] DATA_MAX   = 8'd82;
  localparam logic [7:0] TOTAL_MAX  = 8'd90;
  localparam int         PREFIX_AW  = 7;

  localparam logic [6:0]  SEP_CHAR  = 7'h31;
  localparam logic [7:0]  CHAR_LOW  = 8'd33;
  localparam logic [7:0]  CHAR_HIGH = 8'd126;
  localparam logic [7:0]  UPPER_LOW  = 8'd65;
  localparam logic [7:0]  UPPER_HIGH = 8'd90;
  localparam logic [7:0]  SYM_MAX   = 8'd31;
  localparam logic [7:0]  FIXED_LEN = 8'd8;

  localparam logic [29:0] CHK_INIT = 30'd1;
  localparam logic [29:0] GEN0 = 30'h3b6a57b2;
  localparam logic [29:0] GEN1 = 30'h26508e6d;
  localparam logic [29:0] GEN2 = 30'h1ea119fa;
  localparam logic [29:0] GEN3 = 30'h3d4233dd;
  localparam logic [29:0] GEN4 = 30'h2a1462b3;

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_HRPLEN  = 3'd2,
    ST_SYMBOL  = 3'd3,
    ST_LONG    = 3'd4,
    ST_ORDER   = 3'd5
  } status_t;

  function automatic logic [29:0] poly_step(input logic [29:0] chk, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = chk[29:25];
    r = {chk[24:0], 5'b0} ^ {25'b0, v};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [6:0] letter_of(input logic [4:0] v);
    logic [7:0] b;
    b = CHARSET[{~v, 3'b000} +: 8];
    return b[6:0];
  endfunction

endpackage

[rtl/core/bce_in_if.sv]
interface bce_in_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] symbol_value;
  logic       last_item;

  modport source (output valid, output item_kind, output symbol_value, output last_item,
                  input ready);
  modport sink (input valid, input item_kind, input symbol_value, input last_item,
                output ready);
endinterface

[rtl/core/bce_out_if.sv]
interface bce_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_string;
  logic [2:0] status;

  modport source (output valid, output out_char, output end_of_string, output status,
                  input ready);
  modport sink (input valid, input out_char, input end_of_string, input status,
                output ready);
endinterface

[rtl/core/bech32_checksum_encoder.sv]
// Streaming bech32 encoder. Each HRP character and each data symbol is taken
// while the output register is free, and its character appears on the output
// the next cycle; the first data symbol is held until the HRP is closed. At the
// end of the HRP (first data symbol, or an HRP character marked last) the block
// stops taking items: it sends the separator, then the checksum walks the HRP
// buffer memory one entry per cycle for the high bits, one zero step, one entry
// per cycle for the low bits, and then the pending symbol, if any, is sent.
// After the last item, six zero steps finish the checksum and its six letters
// are sent. A rejected string sends nothing more until its last item, which
// gives one result with out_char 0, end_of_string set and the error status.
module bech32_checksum_encoder
  import bce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bce_in_if.sink    symbols,
  bce_out_if.source chars
);

  typedef enum logic [2:0] {
    S_IN, S_SEP, S_HI, S_ZERO, S_LO, S_SYM, S_POST, S_EMIT
  } state_t;

  state_t         state;
  logic [6:0]     prefix_store [PREFIX_MAX];
  logic [6:0]     rdata;
  logic [PREFIX_AW-1:0] rd_addr;
  logic           wr_en;

  logic [6:0]     prefix_count;
  logic [6:0]     symbol_count;
  logic [29:0]    checksum_reg;
  logic           in_data_phase;
  status_t        error_code;
  logic [6:0]     walk_idx;
  logic [6:0]     walk_idx_next;
  logic           walk_end;
  logic           pend_sym;
  logic           pend_last;
  logic [4:0]     pend_val;
  logic [2:0]     cnt;

  logic           ov;
  logic [6:0]     o_char;
  logic           o_end;
  status_t        o_status;

  logic           slot_free;
  logic           xfer;
  status_t        chk_err;
  logic [7:0]     v;

  assign slot_free     = !ov || chars.ready;
  assign symbols.ready = (state == S_IN) && slot_free;
  assign xfer          = symbols.valid && symbols.ready;
  assign v             = symbols.symbol_value;

  assign chars.valid         = ov;
  assign chars.out_char      = o_char;
  assign chars.end_of_string = o_end;
  assign chars.status        = o_status;

  assign walk_idx_next = walk_idx + 7'd1;
  assign walk_end      = (walk_idx_next == prefix_count);
  assign wr_en = xfer && (error_code == ST_OK) && (chk_err == ST_OK) && !symbols.item_kind;

  always_comb begin
    chk_err = ST_OK;
    if (!symbols.item_kind) begin
      if (in_data_phase) begin
        chk_err = ST_ORDER;
      end else if (v < CHAR_LOW || v > CHAR_HIGH || (v >= UPPER_LOW && v <= UPPER_HIGH)) begin
        chk_err = ST_BADCHAR;
      end else if ({1'b0, prefix_count} >= PREFIX_MAX) begin
        chk_err = ST_HRPLEN;
      end else if ({1'b0, prefix_count} + FIXED_LEN > TOTAL_MAX) begin
        chk_err = ST_LONG;
      end
    end else begin
      if (!in_data_phase && prefix_count == 7'd0) begin
        chk_err = ST_HRPLEN;
      end else if (v > SYM_MAX) begin
        chk_err = ST_SYMBOL;
      end else if ({1'b0, symbol_count} >= DATA_MAX) begin
        chk_err = ST_LONG;
      end else if ({1'b0, prefix_count} + {1'b0, symbol_count} + FIXED_LEN > TOTAL_MAX) begin
        chk_err = ST_LONG;
      end
    end
  end

  always_comb begin
    case (state)
      S_HI, S_LO: rd_addr = walk_end ? '0 : walk_idx_next[PREFIX_AW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_store[prefix_count[PREFIX_AW-1:0]] <= v[6:0];
    end
    rdata <= prefix_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IN;
      ov            <= 1'b0;
      prefix_count  <= '0;
      symbol_count  <= '0;
      checksum_reg  <= CHK_INIT;
      in_data_phase <= 1'b0;
      error_code    <= ST_OK;
      walk_idx      <= '0;
      pend_sym      <= 1'b0;
      pend_last     <= 1'b0;
      cnt           <= '0;
    end else begin
      if (chars.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IN: begin
          if (xfer) begin
            if (error_code != ST_OK || chk_err != ST_OK) begin
              if (error_code == ST_OK) begin
                error_code <= chk_err;
              end
              if (symbols.last_item) begin
                ov            <= 1'b1;
                o_char        <= '0;
                o_end         <= 1'b1;
                o_status      <= (error_code != ST_OK) ? error_code : chk_err;
                prefix_count  <= '0;
                symbol_count  <= '0;
                checksum_reg  <= CHK_INIT;
                in_data_phase <= 1'b0;
                error_code    <= ST_OK;
              end
            end else if (!symbols.item_kind) begin
              ov           <= 1'b1;
              o_char       <= v[6:0];
              o_end        <= 1'b0;
              o_status     <= ST_OK;
              prefix_count <= prefix_count + 7'd1;
              if (symbols.last_item) begin
                pend_sym <= 1'b0;
                state    <= S_SEP;
              end
            end else if (in_data_phase) begin
              ov           <= 1'b1;
              o_char       <= letter_of(v[4:0]);
              o_end        <= 1'b0;
              o_status     <= ST_OK;
              checksum_reg <= poly_step(checksum_reg, v[4:0]);
              symbol_count <= symbol_count + 7'd1;
              if (symbols.last_item) begin
                cnt   <= '0;
                state <= S_POST;
              end
            end else begin
              pend_sym      <= 1'b1;
              pend_val      <= v[4:0];
              pend_last     <= symbols.last_item;
              in_data_phase <= 1'b1;
              state         <= S_SEP;
            end
          end
        end
        S_SEP: begin
          if (slot_free) begin
            ov       <= 1'b1;
            o_char   <= SEP_CHAR;
            o_end    <= 1'b0;
            o_status <= ST_OK;
            walk_idx <= '0;
            state    <= S_HI;
          end
        end
        S_HI: begin
          checksum_reg <= poly_step(checksum_reg, {3'b000, rdata[6:5]});
          if (walk_end) begin
            walk_idx <= '0;
            state    <= S_ZERO;
          end else begin
            walk_idx <= walk_idx_next;
          end
        end
        S_ZERO: begin
          checksum_reg <= poly_step(checksum_reg, 5'd0);
          state        <= S_LO;
        end
        S_LO: begin
          checksum_reg <= poly_step(checksum_reg, rdata[4:0]);
          if (walk_end) begin
            walk_idx <= '0;
            cnt      <= '0;
            state    <= pend_sym ? S_SYM : S_POST;
          end else begin
            walk_idx <= walk_idx_next;
          end
        end
        S_SYM: begin
          if (slot_free) begin
            ov           <= 1'b1;
            o_char       <= letter_of(pend_val);
            o_end        <= 1'b0;
            o_status     <= ST_OK;
            checksum_reg <= poly_step(checksum_reg, pend_val);
            symbol_count <= symbol_count + 7'd1;
            pend_sym     <= 1'b0;
            cnt          <= '0;
            state        <= pend_last ? S_POST : S_IN;
          end
        end
        S_POST: begin
          if (cnt == 3'd5) begin
            checksum_reg <= poly_step(checksum_reg, 5'd0) ^ CHK_INIT;
            cnt          <= '0;
            state        <= S_EMIT;
          end else begin
            checksum_reg <= poly_step(checksum_reg, 5'd0);
            cnt          <= cnt + 3'd1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            ov           <= 1'b1;
            o_char       <= letter_of(checksum_reg[29:25]);
            o_end        <= (cnt == 3'd5);
            o_status     <= ST_OK;
            if (cnt == 3'd5) begin
              cnt           <= '0;
              prefix_count  <= '0;
              symbol_count  <= '0;
              checksum_reg  <= CHK_INIT;
              in_data_phase <= 1'b0;
              error_code    <= ST_OK;
              state         <= S_IN;
            end else begin
              checksum_reg <= {checksum_reg[24:0], 5'b0};
              cnt          <= cnt + 3'd1;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HI || state == S_LO) |-> (walk_idx < prefix_count))
    else $error("walk index beyond buffered prefix");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, prefix_count} <= PREFIX_MAX))
    else $error("prefix count above limit");

  a_data_has_prefix: assert property (@(posedge clk) disable iff (rst)
    in_data_phase |-> (prefix_count != 7'd0))
    else $error("data phase with empty prefix");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (ov && o_status != ST_OK) |-> (o_end && o_char == 7'd0))
    else $error("error result not final or not zero");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_HI || state == S_ZERO || state == S_LO) |-> !symbols.ready)
    else $error("input taken during prefix walk");
`endif

endmodule

[verif/tb_bech32_checksum_encoder.sv]
`timescale 1ns / 1ps

module tb_bech32_checksum_encoder
  import bce_pkg::*;
;

  localparam int QUIET_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 60;

  typedef struct packed {
    logic [6:0] ch;
    logic       eos;
    status_t    st;
  } char_result_t;

  typedef struct {
    bit         kind;
    logic [7:0] value;
  } item_t;

  typedef enum int {
    SH_GOOD, SH_MAXHRP, SH_MAXDATA, SH_BADCHAR, SH_BIGSYM, SH_ORDER,
    SH_NOHRP, SH_LONGHRP, SH_LONGDATA, SH_NOISE
  } string_shape_t;

  class bech32_scoreboard;
    logic [6:0]   hrp_buf [PREFIX_MAX];
    int unsigned  hrp_len;
    int unsigned  sym_len;
    logic [29:0]  chk;
    bit           data_phase;
    status_t      err;
    logic [29:0]  gen_taps [5];
    string        alphabet;
    char_result_t expected_chars [$];
    int           failures;

    function new();
      gen_taps = '{GEN0, GEN1, GEN2, GEN3, GEN4};
      alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
      failures = 0;
      clear();
    endfunction

    function void clear();
      hrp_len = 0;
      sym_len = 0;
      chk = CHK_INIT;
      data_phase = 1'b0;
      err = ST_OK;
    endfunction

    function logic [29:0] bch_step(logic [29:0] c, logic [4:0] v);
      logic [29:0] r;
      r = {c[24:0], 5'b0} ^ {25'b0, v};
      for (int j = 0; j < 5; j++)
        if (c[25 + j]) r = r ^ gen_taps[j];
      return r;
    endfunction

    function logic [6:0] letter(logic [4:0] v);
      byte b;
      b = alphabet[v];
      return b[6:0];
    endfunction

    function void push(logic [6:0] ch, logic eos, status_t st);
      char_result_t r;
      r.ch = ch;
      r.eos = eos;
      r.st = st;
      expected_chars.push_back(r);
    endfunction

    // separator, then high bits, a zero, low bits of the prefix
    function void close_prefix();
      push(SEP_CHAR, 1'b0, ST_OK);
      for (int i = 0; i < hrp_len; i++) chk = bch_step(chk, {3'b0, hrp_buf[i][6:5]});
      chk = bch_step(chk, 5'd0);
      for (int i = 0; i < hrp_len; i++) chk = bch_step(chk, hrp_buf[i][4:0]);
    endfunction

    function void note_item(bit kind, logic [7:0] v, bit is_last);
      logic [29:0] pm;
      if (err == ST_OK) begin
        if (kind == 1'b0) begin
          if (data_phase) err = ST_ORDER;
          else if (v < CHAR_LOW || v > CHAR_HIGH || (v >= UPPER_LOW && v <= UPPER_HIGH))
            err = ST_BADCHAR;
          else if (hrp_len >= PREFIX_MAX) err = ST_HRPLEN;
          else if (hrp_len + FIXED_LEN > TOTAL_MAX) err = ST_LONG;
          else begin
            hrp_buf[hrp_len] = v[6:0];
            hrp_len++;
            push(v[6:0], 1'b0, ST_OK);
            if (is_last) close_prefix();
          end
        end else begin
          if (!data_phase && hrp_len == 0) err = ST_HRPLEN;
          else if (v > SYM_MAX) err = ST_SYMBOL;
          else if (sym_len >= DATA_MAX) err = ST_LONG;
          else if (hrp_len + sym_len + FIXED_LEN > TOTAL_MAX) err = ST_LONG;
          else begin
            if (!data_phase) begin
              close_prefix();
              data_phase = 1'b1;
            end
            push(letter(v[4:0]), 1'b0, ST_OK);
            chk = bch_step(chk, v[4:0]);
            sym_len++;
          end
        end
      end
      if (is_last) begin
        if (err != ST_OK) begin
          push(7'd0, 1'b1, err);
        end else begin
          pm = chk;
          for (int i = 0; i < 6; i++) pm = bch_step(pm, 5'd0);
          pm = pm ^ 30'd1;
          for (int i = 0; i < 6; i++)
            push(letter(pm[25 - 5 * i +: 5]), (i == 5), ST_OK);
        end
        clear();
      end
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_char(logic [6:0] ch, logic eos, logic [2:0] st);
      char_result_t want;
      if (expected_chars.size() == 0) begin
        flag($sformatf("unexpected transfer: char %0h end %0b status %0d", ch, eos, st));
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch || eos !== want.eos || st !== want.st)
        flag($sformatf("mismatch: expected char %0h end %0b status %0d, got %0h %0b %0d",
                       want.ch, want.eos, want.st, ch, eos, st));
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  bce_in_if  symbols ();
  bce_out_if chars ();

  bech32_checksum_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .chars   (chars)
  );

  bech32_scoreboard sb = new();
  item_t seq [$];
  int    items_taken = 0;
  int    tx_burst = 0;
  bit    held = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 63) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(bit kind, logic [7:0] v, bit is_last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      symbols.valid <= 1'b0;
    end
    @(negedge clk);
    symbols.valid        <= 1'b1;
    symbols.item_kind    <= kind;
    symbols.symbol_value <= v;
    symbols.last_item    <= is_last;
    do @(posedge clk); while (!symbols.ready);
    sb.note_item(kind, v, is_last);
    items_taken++;
  endtask

  function automatic void push_hrp(logic [7:0] v);
    item_t it;
    it.kind = 1'b0;
    it.value = v;
    seq.push_back(it);
  endfunction

  function automatic void push_sym(logic [7:0] v);
    item_t it;
    it.kind = 1'b1;
    it.value = v;
    seq.push_back(it);
  endfunction

  task automatic flush_string();
    for (int i = 0; i < seq.size(); i++)
      send_item(seq[i].kind, seq[i].value, i == seq.size() - 1);
    seq.delete();
  endtask

  function automatic logic [7:0] good_hrp_char();
    logic [7:0] v;
    v = 8'($urandom_range(33, 126));
    if (v >= UPPER_LOW && v <= UPPER_HIGH) v = v + 8'd32;
    return v;
  endfunction

  function automatic logic [7:0] bad_hrp_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 32));
      1: return 8'($urandom_range(127, 255));
      default: return 8'($urandom_range(65, 90));
    endcase
  endfunction

  function automatic void push_good_hrp(int n);
    for (int i = 0; i < n; i++) push_hrp(good_hrp_char());
  endfunction

  function automatic void push_good_syms(int n);
    for (int i = 0; i < n; i++) push_sym(8'($urandom_range(0, 31)));
  endfunction

  function automatic void build_string(string_shape_t shape);
    int n;
    int d;
    int cap;
    int pos;
    case (shape)
      SH_GOOD: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 83) : $urandom_range(1, 6);
        cap = (n >= 82) ? 0 : 82 - n;
        if ($urandom_range(0, 7) == 0) d = $urandom_range(0, cap);
        else d = $urandom_range(0, (cap < 12) ? cap : 12);
        push_good_hrp(n);
        push_good_syms(d);
      end
      SH_MAXHRP: push_good_hrp(83);
      SH_MAXDATA: begin
        push_good_hrp(1);
        push_good_syms(82);
      end
      SH_BADCHAR: begin
        n = $urandom_range(1, 6);
        pos = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) push_hrp((i == pos) ? bad_hrp_char() : good_hrp_char());
        push_good_syms($urandom_range(0, 3));
      end
      SH_BIGSYM: begin
        n = $urandom_range(1, 4);
        d = $urandom_range(1, 6);
        pos = $urandom_range(0, d - 1);
        push_good_hrp(n);
        for (int i = 0; i < d; i++)
          push_sym((i == pos) ? 8'($urandom_range(32, 255)) : 8'($urandom_range(0, 31)));
      end
      SH_ORDER: begin
        push_good_hrp($urandom_range(1, 4));
        push_good_syms($urandom_range(1, 4));
        push_hrp(good_hrp_char());
        push_good_syms($urandom_range(0, 2));
      end
      SH_NOHRP: push_good_syms($urandom_range(1, 4));
      SH_LONGHRP: begin
        push_good_hrp($urandom_range(84, 86));
        push_good_syms($urandom_range(0, 1));
      end
      SH_LONGDATA: begin
        n = $urandom_range(1, 4);
        push_good_hrp(n);
        push_good_syms(84 - n + $urandom_range(0, 2));
      end
      default: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          if ($urandom_range(0, 1)) push_sym(8'($urandom_range(0, 255)));
          else push_hrp(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  function automatic string_shape_t pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return SH_GOOD;
    if (r < 68) return SH_BADCHAR;
    if (r < 74) return SH_BIGSYM;
    if (r < 80) return SH_ORDER;
    if (r < 84) return SH_NOHRP;
    if (r < 96) return SH_NOISE;
    if (r == 96) return SH_LONGHRP;
    if (r == 97) return SH_LONGDATA;
    if (r == 98) return SH_MAXHRP;
    return SH_MAXDATA;
  endfunction

  task automatic run_directed();
    // empty data part
    push_hrp("a");
    flush_string();
    // character range edges and symbol edges
    push_hrp(8'd33); push_hrp("@"); push_hrp("["); push_hrp(8'd126);
    push_sym(8'd0); push_sym(8'd31);
    flush_string();
    // bad prefix characters
    push_hrp(8'd32);  flush_string();
    push_hrp(8'd127); flush_string();
    push_hrp("A");    flush_string();
    push_hrp("Z");    flush_string();
    push_hrp(8'hff);  flush_string();
    // data with no prefix
    push_sym(8'd5);
    flush_string();
    // symbol over range
    push_hrp("x"); push_sym(8'd32);
    flush_string();
    push_hrp("q"); push_sym(8'hff);
    flush_string();
    // prefix character after data
    push_hrp("a"); push_sym(8'd1); push_hrp("b");
    flush_string();
    // items after an error are ignored
    push_hrp("a"); push_hrp(8'd33 - 8'd1); push_sym(8'd3);
    flush_string();
  endtask

  task automatic run_random();
    for (int s = SH_GOOD; s <= SH_NOISE; s++) begin
      if (s == SH_MAXDATA) continue;
      build_string(string_shape_t'(s));
      flush_string();
    end
    while (items_taken < ITEM_TARGET) begin
      build_string(pick_shape());
      flush_string();
    end
  endtask

  // receiver side, with one long hold-off once traffic is under way
  initial begin
    int r;
    int len;
    bit level;
    chars.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && items_taken >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          chars.ready <= 1'b0;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        level = 1'b1;
        len = $urandom_range(40, 120);
      end else if (r < 13) begin
        level = 1'b0;
        len = $urandom_range(15, 50);
      end else if (r < 40) begin
        level = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        len = $urandom_range(1, 10);
      end
      repeat (len) begin
        @(negedge clk);
        chars.ready <= level;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && chars.valid && chars.ready)
      sb.check_char(chars.out_char, chars.end_of_string, chars.status);
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (symbols.valid && symbols.ready) || (chars.valid && chars.ready)) quiet = 0;
      else quiet++;
    end
    $display("bech32_checksum_encoder regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    symbols.valid = 1'b0;
    symbols.item_kind = 1'b0;
    symbols.symbol_value = 8'd0;
    symbols.last_item = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    @(negedge clk);
    symbols.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("bech32_checksum_encoder regression: pass");
    else
      $display("bech32_checksum_encoder regression: fail");
    $finish;
  end

endmodule
